// File: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and sizes of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Capacity of the queue (number of slots)
	localparam int QUEUE_DEPTH = 32;
	// Width of the entry counter, able to hold QUEUE_DEPTH itself
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	// Width of the occupancy field
	localparam int OCC_W = 6;

	// Operation codes
	localparam logic [1:0] MODE_PUSH = 2'd0;
	localparam logic [1:0] MODE_POP  = 2'd1;
	localparam logic [1:0] MODE_PEEK = 2'd2;

	// Result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// One stored entry
	typedef struct packed {
		logic [15:0]        id;
		logic signed [31:0] value;
		logic signed [15:0] prio;
	} entry_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;   // capture the command fields
		logic exec;   // perform the operation on the slot array
	} ctl_cmd_t;

	// One result transfer
	typedef struct packed {
		logic [1:0]       status;
		entry_t           head;
		logic [OCC_W-1:0] occupancy;
	} result_t;

endpackage

// File: design/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: takes a command, runs it through the datapath, strobes done.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output spq_pkg::ctl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	logic   done_q;
	logic   accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign cmd.load = accept;
	assign cmd.exec = (state_q == ST_EXEC);

	// State register and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;

endmodule

// File: design/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted slot array with one priority comparator per slot, entry counter
// and result registers.
// ----------------------------------------------------------------------------
module spq_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  spq_pkg::ctl_cmd_t   cmd,
	input  logic [1:0]          mode,
	input  logic [15:0]         entry_id,
	input  logic signed [31:0]  entry_value,
	input  logic signed [15:0]  entry_priority,
	output spq_pkg::result_t    result
);

	localparam int D = spq_pkg::QUEUE_DEPTH;
	localparam int W = spq_pkg::CNT_W;

	logic [1:0]              mode_q;
	spq_pkg::entry_t         new_q;
	spq_pkg::entry_t         slot_q [D];
	logic [W-1:0]            count_q;
	logic [W-1:0]            count_nx;
	spq_pkg::result_t        result_q;

	logic                    full;
	logic                    empty;
	logic                    do_push;
	logic                    do_pop;
	logic [D-1:0]            ge;
	logic [D-1:0]            prev_ge;

	// Command capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q      <= mode;
			new_q.id    <= entry_id;
			new_q.value <= entry_value;
			new_q.prio  <= entry_priority;
		end
	end

	assign full    = (count_q == W'(D));
	assign empty   = (count_q == '0);
	assign do_push = cmd.exec && (mode_q == spq_pkg::MODE_PUSH) && !full;
	assign do_pop  = cmd.exec && (mode_q == spq_pkg::MODE_POP) && !empty;

	// Per-slot compare: stored entry stays ahead of the new one
	always_comb begin
		for (int i = 0; i < D; i++) begin
			ge[i] = (W'(i) < count_q) && (slot_q[i].prio >= new_q.prio);
		end
		prev_ge = {ge[D-2:0], 1'b1};
	end

	// Slot array: insert at the first slot that does not stay ahead,
	// shift the rest back; pop shifts everything forward
	for (genvar g = 0; g < D; g++) begin : g_slot
		spq_pkg::entry_t from_prev;
		spq_pkg::entry_t from_next;

		if (g == 0) begin : g_first
			assign from_prev = new_q;
		end else begin : g_mid
			assign from_prev = slot_q[g-1];
		end

		if (g == D - 1) begin : g_last
			assign from_next = slot_q[g];
		end else begin : g_inner
			assign from_next = slot_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (do_push) begin
				if (!ge[g] && prev_ge[g])
					slot_q[g] <= new_q;
				else if (!ge[g])
					slot_q[g] <= from_prev;
			end else if (do_pop) begin
				slot_q[g] <= from_next;
			end
		end
	end

	// Next entry count
	always_comb begin
		count_nx = count_q;
		if (do_push)
			count_nx = count_q + W'(1);
		else if (do_pop)
			count_nx = count_q - W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else
			count_q <= count_nx;
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			result_q.status    <= spq_pkg::STAT_OK;
			result_q.head      <= '0;
			result_q.occupancy <= spq_pkg::OCC_W'(count_nx);
			case (mode_q)
				spq_pkg::MODE_PUSH: begin
					if (full)
						result_q.status <= spq_pkg::STAT_FULL;
				end
				spq_pkg::MODE_POP, spq_pkg::MODE_PEEK: begin
					if (empty)
						result_q.status <= spq_pkg::STAT_EMPTY;
					else
						result_q.head <= slot_q[0];
				end
				default: begin
					result_q.status <= spq_pkg::STAT_OK;
				end
			endcase
		end
	end

	assign result = result_q;

endmodule

// File: design/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted, head first; push, pop and peek.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command
// is first captured; then, in the execute state, all slots compare
// their priority against the new entry in parallel and shift or insert in
// a single step. The result appears on the result ports for exactly one
// cycle with done high, in the cycle after that step; busy is already low
// then, so the next command can be taken while done is high, though none
// during an execute step. The receiver cannot hold results off and must
// take each one while done is high. Entries of equal priority leave first
// in, first out. A push on a full queue is refused with status full; pop
// or peek on an empty queue gives status empty with zero head fields.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic [15:0]        entry_id,
	input  logic signed [31:0] entry_value,
	input  logic signed [15:0] entry_priority,
	output logic               done,
	output logic [1:0]         status,
	output logic [15:0]        head_id,
	output logic signed [31:0] head_value,
	output logic signed [15:0] head_priority,
	output logic [5:0]         occupancy
);

	spq_pkg::ctl_cmd_t cmd;
	spq_pkg::result_t  result;

	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	spq_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.mode           (mode),
		.entry_id       (entry_id),
		.entry_value    (entry_value),
		.entry_priority (entry_priority),
		.result         (result)
	);

	// Result transfer fields
	assign status        = result.status;
	assign head_id       = result.head.id;
	assign head_value    = result.head.value;
	assign head_priority = result.head.prio;
	assign occupancy     = result.occupancy;

endmodule

// File: tb/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Watches the command and result channels of the sorted priority queue,
// keeps its own sorted copy of the queue and checks every result against it.
// ----------------------------------------------------------------------------
module spq_checker
	import spq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         mode,
	input  logic [15:0]        entry_id,
	input  logic signed [31:0] entry_value,
	input  logic signed [15:0] entry_priority,
	input  logic               done,
	input  logic [1:0]         status,
	input  logic [15:0]        head_id,
	input  logic signed [31:0] head_value,
	input  logic signed [15:0] head_priority,
	input  logic [5:0]         occupancy,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the queue, head at slot 0
	entry_t  slots [QUEUE_DEPTH];
	int      stored_n;
	result_t results_due [$];

	initial begin
		fail_count = 0;
		pending = 0;
		stored_n = 0;
	end

	// Apply one command to the shadow queue and return the result it gives
	function automatic result_t apply_command(input logic [1:0] m, input entry_t e);
		result_t r;
		int      pos;
		r = '0;
		case (m)
			MODE_PUSH: begin
				if (stored_n >= QUEUE_DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					// insert behind all entries of equal or higher priority
					pos = 0;
					while (pos < stored_n && $signed(slots[pos].prio) >= $signed(e.prio))
						pos++;
					for (int i = stored_n; i > pos; i--)
						slots[i] = slots[i-1];
					slots[pos] = e;
					stored_n++;
					r.status = STAT_OK;
				end
			end
			MODE_POP, MODE_PEEK: begin
				if (stored_n == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.status = STAT_OK;
					r.head = slots[0];
					if (m == MODE_POP) begin
						for (int i = 0; i < stored_n - 1; i++)
							slots[i] = slots[i+1];
						stored_n--;
					end
				end
			end
			default: r.status = STAT_OK;  // unused code: queue untouched
		endcase
		r.occupancy = stored_n[OCC_W-1:0];
		return r;
	endfunction

	task automatic check_field(input string field, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	// Result check first, then capture of a newly accepted command
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		entry_t  pushed;
		if (!arst_n) begin
			results_due.delete();
			stored_n = 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (results_due.size() == 0) begin
					$display("%0t: result with none expected: status %0d, occupancy %0d",
						$time, status, occupancy);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					check_field("status", want.status, status);
					check_field("head_id", want.head.id, head_id);
					check_field("head_value", $signed(want.head.value), head_value);
					check_field("head_priority", $signed(want.head.prio), head_priority);
					check_field("occupancy", want.occupancy, occupancy);
				end
			end
			if (start && !busy) begin
				pushed.id = entry_id;
				pushed.value = entry_value;
				pushed.prio = entry_priority;
				results_due.push_back(apply_command(mode, pushed));
			end
			pending <= results_due.size();
		end
	end

endmodule

// File: tb/tb_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Drives directed and random push, pop and peek commands in bursts into the
// sorted priority queue; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
	import spq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_COMMANDS = 800;
	localparam int STALL_LIMIT = 1000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         mode = MODE_PUSH;
	logic [15:0]        entry_id = '0;
	logic signed [31:0] entry_value = '0;
	logic signed [15:0] entry_priority = '0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic [15:0]        head_id;
	logic signed [31:0] head_value;
	logic signed [15:0] head_priority;
	logic [5:0]         occupancy;
	int                 fail_count;
	int                 pending;
	int                 idle_cycles;
	int                 burst_left;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sorted_priority_queue dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.entry_id(entry_id), .entry_value(entry_value), .entry_priority(entry_priority),
		.done(done), .status(status), .head_id(head_id), .head_value(head_value),
		.head_priority(head_priority), .occupancy(occupancy)
	);

	spq_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.entry_id(entry_id), .entry_value(entry_value), .entry_priority(entry_priority),
		.done(done), .status(status), .head_id(head_id), .head_value(head_value),
		.head_priority(head_priority), .occupancy(occupancy),
		.fail_count(fail_count), .pending(pending)
	);

	// Watchdog: cycles without any transfer on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	// One command transfer, then maybe a gap closing the current burst
	task automatic issue(input logic [1:0] m, input logic [15:0] id,
			input logic signed [31:0] val, input logic signed [15:0] pr);
		int gap;
		start <= 1'b1;
		mode <= m;
		entry_id <= id;
		entry_value <= val;
		entry_priority <= pr;
		do @(posedge clk); while (busy);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		int                 counted;
		int                 roll;
		int                 push_cut;
		int                 pop_cut;
		logic [1:0]         m;
		logic signed [15:0] pr;

		burst_left = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queue, field extremes, ties, unused code, drain
		issue(MODE_PEEK, 16'h0000, 32'sd0, 16'sd0);
		issue(MODE_POP, 16'hffff, -32'sd1, -16'sd1);
		issue(MODE_PUSH, 16'h0000, 32'sh8000_0000, 16'sh8000);
		issue(MODE_PUSH, 16'hffff, 32'sh7fff_ffff, 16'sh7fff);
		issue(MODE_PEEK, 16'h0000, 32'sd0, 16'sd0);
		issue(MODE_PUSH, 16'h0001, 32'sd100, 16'sd0);
		issue(MODE_PUSH, 16'h0002, 32'sd200, 16'sd0);
		issue(MODE_PUSH, 16'h0003, 32'sd300, 16'sd0);
		issue(MODE_PUSH, 16'haaaa, 32'sh5555_5555, 16'sh7fff);
		issue(MODE_UNUSED, 16'h5555, 32'shaaaa_aaaa, 16'sh5555);
		issue(MODE_PUSH, 16'h5555, 32'shaaaa_aaaa, 16'sh8000);
		issue(MODE_POP, 16'h0000, 32'sd0, 16'sd0);
		issue(MODE_POP, 16'h0000, 32'sd0, 16'sd0);
		issue(MODE_PEEK, 16'h0000, 32'sd0, 16'sd0);
		issue(MODE_POP, 16'h0000, 32'sd0, 16'sd0);
		issue(MODE_POP, 16'h0000, 32'sd0, 16'sd0);
		issue(MODE_POP, 16'h0000, 32'sd0, 16'sd0);
		issue(MODE_POP, 16'h0000, 32'sd0, 16'sd0);
		issue(MODE_POP, 16'h0000, 32'sd0, 16'sd0);
		issue(MODE_POP, 16'h0000, 32'sd0, 16'sd0);
		issue(MODE_PEEK, 16'h0000, 32'sd0, 16'sd0);

		// Random: fill-heavy and drain-heavy phases picked at random so the queue hits both ends
		counted = 0;
		while (counted < RANDOM_COMMANDS) begin
			push_cut = $urandom_range(0, 1) ? 80 : 30;
			pop_cut = (push_cut == 80) ? 92 : 85;
			repeat ($urandom_range(10, 60)) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					m = MODE_UNUSED;
				else if (roll < push_cut)
					m = MODE_PUSH;
				else if (roll < pop_cut)
					m = MODE_POP;
				else
					m = MODE_PEEK;
				// crowd priorities onto a few values for ties, plus the extremes
				roll = $urandom_range(0, 9);
				if (roll < 4)
					pr = $signed(16'($urandom_range(0, 4))) - 16'sd2;
				else if (roll < 6)
					case ($urandom_range(0, 3))
						0: pr = 16'sh8000;
						1: pr = 16'sh8001;
						2: pr = 16'sh7ffe;
						default: pr = 16'sh7fff;
					endcase
				else
					pr = $signed(16'($urandom));
				issue(m, 16'($urandom), $signed(32'($urandom)), pr);
				if (m != MODE_UNUSED)
					counted++;
			end
		end

		// Drain the outstanding results, then a short tail for stray strobes
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
